>>> src/apm_pkg.sv
package apm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ALT_SETPOINT  = 3'd0,
    REG_ALT_P_GAIN    = 3'd1,
    REG_ALT_D_GAIN    = 3'd2,
    REG_ALT_I_GAIN    = 3'd3,
    REG_GRAVITY_FF    = 3'd4,
    REG_TILT_P_GAIN   = 3'd5,
    REG_TILT_D_GAIN   = 3'd6,
    REG_SERVO_LIMIT   = 3'd7
  } reg_idx_t;

  // Register reset values
  localparam logic [31:0] RST_ALT_SETPOINT  = 32'd131072;
  localparam logic [31:0] RST_ALT_P_GAIN    = 32'd32768;
  localparam logic [31:0] RST_ALT_D_GAIN    = 32'd1310720;
  localparam logic [31:0] RST_ALT_I_GAIN    = 32'd66;
  localparam logic [31:0] RST_GRAVITY_FF    = 32'd1376256;
  localparam logic [31:0] RST_TILT_P_GAIN   = 32'd6554;
  localparam logic [31:0] RST_TILT_D_GAIN   = 32'd13107;
  localparam logic [30:0] RST_SERVO_LIMIT   = 31'd17157;

  // Fixed yaw gains, unsigned Q16.16
  localparam logic [31:0] TORQUE_P_GAIN = 32'd3277;
  localparam logic [31:0] TORQUE_D_GAIN = 32'd328;

  // Integrator limits
  localparam logic signed [47:0] ISUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ISUM_MIN = 48'sh8000_0000_0000;

  // Product term clamp, +/- 2^60
  localparam logic signed [64:0] TERM_CAP   = 65'sh0_1000_0000_0000_0000;
  localparam logic signed [64:0] TERM_FLOOR = -TERM_CAP;

  typedef struct packed {
    logic signed [31:0] alt_setpoint;
    logic        [31:0] alt_p_gain;
    logic        [31:0] alt_d_gain;
    logic        [31:0] alt_i_gain;
    logic signed [31:0] gravity_ff;
    logic        [31:0] tilt_p_gain;
    logic        [31:0] tilt_d_gain;
    logic        [30:0] servo_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] altitude;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } sample_t;

  // Multiplier operands
  typedef struct packed {
    logic signed [32:0] err;
    logic signed [32:0] dalt;
    logic signed [47:0] esum;
    logic signed [32:0] nqx;
    logic signed [32:0] dqx;
    logic signed [32:0] nqy;
    logic signed [32:0] dqy;
    logic signed [32:0] nqz;
    logic signed [32:0] dqz;
  } ops_t;

  // Exact products; the integrator product is split in two partials
  typedef struct packed {
    logic signed [65:0] err;
    logic signed [65:0] dalt;
    logic signed [56:0] int_hi;
    logic        [55:0] int_lo;
    logic signed [65:0] nqx;
    logic signed [65:0] dqx;
    logic signed [65:0] nqy;
    logic signed [65:0] dqy;
    logic signed [65:0] nqz;
    logic signed [65:0] dqz;
  } prod_t;

  // Scaled and clamped terms
  typedef struct packed {
    logic signed [61:0] err;
    logic signed [61:0] dalt;
    logic signed [61:0] integ;
    logic signed [61:0] nqx;
    logic signed [61:0] dqx;
    logic signed [61:0] nqy;
    logic signed [61:0] dqy;
    logic signed [61:0] nqz;
    logic signed [61:0] dqz;
  } term_t;

  typedef struct packed {
    logic signed [31:0] servo_a;
    logic signed [31:0] servo_b;
    logic signed [31:0] top_rotor;
    logic signed [31:0] bottom_rotor;
  } result_t;

  // Floor-scale a 33 by 33 product by 2^-16; magnitude stays far below the clamp
  function automatic logic signed [61:0] prod_term(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p >>> 16;
    return s[61:0];
  endfunction

  // Join the integrator partials, floor-scale by 2^-16 and clamp to +/- 2^60
  function automatic logic signed [61:0] int_term(input logic signed [56:0] hi,
                                                  input logic        [55:0] lo);
    logic signed [80:0] full;
    logic signed [64:0] q;
    full = ($signed({{24{hi[56]}}, hi}) <<< 24) + $signed({25'd0, lo});
    q = full[80:16];
    if (q > TERM_CAP) begin
      q = TERM_CAP;
    end else if (q < TERM_FLOOR) begin
      q = TERM_FLOOR;
    end
    return q[61:0];
  endfunction

endpackage

>>> src/apm_cfg_regs.sv
module apm_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  output apm_pkg::cfg_t      cfg
);

  apm_pkg::cfg_t cfg_r;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alt_setpoint  <= apm_pkg::RST_ALT_SETPOINT;
      cfg_r.alt_p_gain    <= apm_pkg::RST_ALT_P_GAIN;
      cfg_r.alt_d_gain    <= apm_pkg::RST_ALT_D_GAIN;
      cfg_r.alt_i_gain    <= apm_pkg::RST_ALT_I_GAIN;
      cfg_r.gravity_ff    <= apm_pkg::RST_GRAVITY_FF;
      cfg_r.tilt_p_gain   <= apm_pkg::RST_TILT_P_GAIN;
      cfg_r.tilt_d_gain   <= apm_pkg::RST_TILT_D_GAIN;
      cfg_r.servo_limit   <= apm_pkg::RST_SERVO_LIMIT;
    end else if (cfg_we) begin
      case (apm_pkg::reg_idx_t'(cfg_addr))
        apm_pkg::REG_ALT_SETPOINT:  cfg_r.alt_setpoint  <= cfg_wdata;
        apm_pkg::REG_ALT_P_GAIN:    cfg_r.alt_p_gain    <= cfg_wdata;
        apm_pkg::REG_ALT_D_GAIN:    cfg_r.alt_d_gain    <= cfg_wdata;
        apm_pkg::REG_ALT_I_GAIN:    cfg_r.alt_i_gain    <= cfg_wdata;
        apm_pkg::REG_GRAVITY_FF:    cfg_r.gravity_ff    <= cfg_wdata;
        apm_pkg::REG_TILT_P_GAIN:   cfg_r.tilt_p_gain   <= cfg_wdata;
        apm_pkg::REG_TILT_D_GAIN:   cfg_r.tilt_d_gain   <= cfg_wdata;
        apm_pkg::REG_SERVO_LIMIT:   cfg_r.servo_limit   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/apm_front.sv
module apm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apm_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  apm_pkg::sample_t     up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output apm_pkg::ops_t        dn_data
);

  logic signed [31:0] last_alt_r, last_qx_r, last_qy_r, last_qz_r;
  logic signed [47:0] esum_r, esum_nxt;
  logic               valid_r;
  apm_pkg::ops_t      ops_r, ops_nxt;
  logic               accept;
  logic signed [48:0] esum_wide;

  assign up_ready = !valid_r || dn_ready;
  assign accept   = up_valid && up_ready;

  // Form operands: error, negated quaternions, sample differences and the integrator as it stood
  always_comb begin
    ops_nxt.err  = $signed({cfg.alt_setpoint[31], cfg.alt_setpoint})
                 - $signed({up_data.altitude[31], up_data.altitude});
    ops_nxt.dalt = $signed({last_alt_r[31], last_alt_r})
                 - $signed({up_data.altitude[31], up_data.altitude});
    ops_nxt.esum = esum_r;
    ops_nxt.nqx  = 33'sd0 - $signed({up_data.quat_x[31], up_data.quat_x});
    ops_nxt.dqx  = $signed({last_qx_r[31], last_qx_r})
                 - $signed({up_data.quat_x[31], up_data.quat_x});
    ops_nxt.nqy  = 33'sd0 - $signed({up_data.quat_y[31], up_data.quat_y});
    ops_nxt.dqy  = $signed({last_qy_r[31], last_qy_r})
                 - $signed({up_data.quat_y[31], up_data.quat_y});
    ops_nxt.nqz  = 33'sd0 - $signed({up_data.quat_z[31], up_data.quat_z});
    ops_nxt.dqz  = $signed({last_qz_r[31], last_qz_r})
                 - $signed({up_data.quat_z[31], up_data.quat_z});
  end

  // Saturating integrator update
  always_comb begin
    esum_wide = $signed({esum_r[47], esum_r}) + $signed({{16{ops_nxt.err[32]}}, ops_nxt.err});
    if (esum_wide[48] != esum_wide[47]) begin
      esum_nxt = esum_wide[48] ? apm_pkg::ISUM_MIN : apm_pkg::ISUM_MAX;
    end else begin
      esum_nxt = esum_wide[47:0];
    end
  end

  // Hold previous sample and integrator, advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_alt_r <= '0;
      last_qx_r  <= '0;
      last_qy_r  <= '0;
      last_qz_r  <= '0;
      esum_r     <= '0;
    end else if (accept) begin
      last_alt_r <= up_data.altitude;
      last_qx_r  <= up_data.quat_x;
      last_qy_r  <= up_data.quat_y;
      last_qz_r  <= up_data.quat_z;
      esum_r     <= esum_nxt;
    end
  end

  // Operand register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ops_r <= ops_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = ops_r;

endmodule

>>> src/apm_mul.sv
module apm_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apm_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  apm_pkg::ops_t        up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output apm_pkg::term_t       dn_data
);

  logic           prod_valid_r, term_valid_r;
  logic           prod_ready, term_ready;
  apm_pkg::prod_t prod_r;
  apm_pkg::term_t term_r;

  assign term_ready = !term_valid_r || dn_ready;
  assign prod_ready = !prod_valid_r || term_ready;
  assign up_ready   = prod_ready;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      term_valid_r <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= up_valid;
      end
      if (term_ready) begin
        term_valid_r <= prod_valid_r;
      end
    end
  end

  // Product stage: operand times unsigned gain, exact
  always_ff @(posedge clk) begin
    if (prod_ready && up_valid) begin
      prod_r.err    <= up_data.err  * $signed({1'b0, cfg.alt_p_gain});
      prod_r.dalt   <= up_data.dalt * $signed({1'b0, cfg.alt_d_gain});
      prod_r.int_hi <= $signed(up_data.esum[47:24]) * $signed({1'b0, cfg.alt_i_gain});
      prod_r.int_lo <= up_data.esum[23:0] * cfg.alt_i_gain;
      prod_r.nqx    <= up_data.nqx * $signed({1'b0, cfg.tilt_p_gain});
      prod_r.dqx    <= up_data.dqx * $signed({1'b0, cfg.tilt_d_gain});
      prod_r.nqy    <= up_data.nqy * $signed({1'b0, cfg.tilt_p_gain});
      prod_r.dqy    <= up_data.dqy * $signed({1'b0, cfg.tilt_d_gain});
      prod_r.nqz    <= up_data.nqz * $signed({1'b0, apm_pkg::TORQUE_P_GAIN});
      prod_r.dqz    <= up_data.dqz * $signed({1'b0, apm_pkg::TORQUE_D_GAIN});
    end
  end

  // Term stage: scale by 2^-16 with floor, clamp the integrator term
  always_ff @(posedge clk) begin
    if (term_ready && prod_valid_r) begin
      term_r.err   <= apm_pkg::prod_term(prod_r.err);
      term_r.dalt  <= apm_pkg::prod_term(prod_r.dalt);
      term_r.integ <= apm_pkg::int_term(prod_r.int_hi, prod_r.int_lo);
      term_r.nqx   <= apm_pkg::prod_term(prod_r.nqx);
      term_r.dqx   <= apm_pkg::prod_term(prod_r.dqx);
      term_r.nqy   <= apm_pkg::prod_term(prod_r.nqy);
      term_r.dqy   <= apm_pkg::prod_term(prod_r.dqy);
      term_r.nqz   <= apm_pkg::prod_term(prod_r.nqz);
      term_r.dqz   <= apm_pkg::prod_term(prod_r.dqz);
    end
  end

  assign dn_valid = term_valid_r;
  assign dn_data  = term_r;

endmodule

>>> src/apm_mix.sv
module apm_mix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apm_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  apm_pkg::term_t       up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output apm_pkg::result_t     dn_data
);

  localparam logic signed [63:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = 64'shFFFF_FFFF_8000_0000;

  logic               sum_valid_r, out_valid_r;
  logic               sum_ready, out_ready;
  logic signed [63:0] thrust_r, torque_r;
  logic signed [31:0] servo_a_r, servo_b_r;
  logic signed [63:0] thrust_nxt, torque_nxt, sa_sum, sb_sum, lim_pos, lim_neg;
  logic signed [31:0] servo_a_nxt, servo_b_nxt;
  logic signed [64:0] top_sum, bot_sum;
  logic signed [63:0] top_half, bot_half;
  apm_pkg::result_t   out_r;
  logic signed [31:0] top_nxt, bot_nxt;

  function automatic logic signed [63:0] sx62(input logic signed [61:0] v);
    return $signed({{2{v[61]}}, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX[31:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[31:0];
    end
    return v[31:0];
  endfunction

  assign out_ready = !out_valid_r || dn_ready;
  assign sum_ready = !sum_valid_r || out_ready;
  assign up_ready  = sum_ready;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_r <= up_valid;
      end
      if (out_ready) begin
        out_valid_r <= sum_valid_r;
      end
    end
  end

  // Sum terms, clamp servos to the limit
  always_comb begin
    thrust_nxt = $signed({{32{cfg.gravity_ff[31]}}, cfg.gravity_ff})
               + sx62(up_data.err) + sx62(up_data.dalt) + sx62(up_data.integ);
    torque_nxt = sx62(up_data.nqz) + sx62(up_data.dqz);
    sa_sum     = sx62(up_data.nqy) + sx62(up_data.dqy);
    sb_sum     = sx62(up_data.nqx) + sx62(up_data.dqx);
    lim_pos    = $signed({33'd0, cfg.servo_limit});
    lim_neg    = -lim_pos;
    if (sa_sum > lim_pos) begin
      servo_a_nxt = lim_pos[31:0];
    end else if (sa_sum < lim_neg) begin
      servo_a_nxt = lim_neg[31:0];
    end else begin
      servo_a_nxt = sa_sum[31:0];
    end
    if (sb_sum > lim_pos) begin
      servo_b_nxt = lim_pos[31:0];
    end else if (sb_sum < lim_neg) begin
      servo_b_nxt = lim_neg[31:0];
    end else begin
      servo_b_nxt = sb_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && up_valid) begin
      thrust_r  <= thrust_nxt;
      torque_r  <= torque_nxt;
      servo_a_r <= servo_a_nxt;
      servo_b_r <= servo_b_nxt;
    end
  end

  // Mix rotors: floor half of thrust +/- torque, saturate to 32 bits
  always_comb begin
    top_sum  = $signed({thrust_r[63], thrust_r}) + $signed({torque_r[63], torque_r});
    bot_sum  = $signed({thrust_r[63], thrust_r}) - $signed({torque_r[63], torque_r});
    top_half = top_sum[64:1];
    bot_half = bot_sum[64:1];
    top_nxt  = sat32(top_half);
    bot_nxt  = sat32(bot_half);
  end

  always_ff @(posedge clk) begin
    if (out_ready && sum_valid_r) begin
      out_r.servo_a      <= servo_a_r;
      out_r.servo_b      <= servo_b_r;
      out_r.top_rotor    <= top_nxt;
      out_r.bottom_rotor <= bot_nxt;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_data  = out_r;

endmodule

>>> src/altitude_pid_attitude_pd_mixer.sv
// Altitude PID, attitude PD and two-rotor mixer.
// Input stream (in_*): one state sample per word, altitude and quaternion
// x, y, z in signed Q16.16. Result stream (out_*): one word per sample with
// the two servo commands and the top and bottom rotor commands.
// Configuration (cfg_*): write-only register file, one register per cycle
// while cfg_we is high; write it only while no sample is in flight.
// Pipeline: a result passes through the operand, product, term, sum and
// output registers, in that order, after its sample is accepted.
// Throughput: one sample per cycle unless the receiver stalls; every stage
// holds one word and the only feedback is the previous sample and the
// integrator, updated on accept. Each stage moves on when its successor has
// room, so bubbles close up and a stalled receiver backs the pipeline up one
// stage at a time; in_tready drops only when all five stages are full.
// Reset: registers return to their defaults, the previous sample and the
// integrator clear to zero and the pipeline empties.
module altitude_pid_attitude_pd_mixer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // altitude, quat_x, quat_y, quat_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // servo_a, servo_b, top_rotor, bottom_rotor
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  apm_pkg::cfg_t    cfg;
  apm_pkg::sample_t sample;
  apm_pkg::ops_t    ops;
  apm_pkg::term_t   terms;
  apm_pkg::result_t result;
  logic             ops_valid, ops_ready, term_valid, term_ready;

  // Unpack the input word, lowest field first
  assign sample.altitude = in_tdata[31:0];
  assign sample.quat_x   = in_tdata[63:32];
  assign sample.quat_y   = in_tdata[95:64];
  assign sample.quat_z   = in_tdata[127:96];

  apm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  apm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (sample),
    .dn_valid (ops_valid),
    .dn_ready (ops_ready),
    .dn_data  (ops)
  );

  apm_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (ops_valid),
    .up_ready (ops_ready),
    .up_data  (ops),
    .dn_valid (term_valid),
    .dn_ready (term_ready),
    .dn_data  (terms)
  );

  apm_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (term_valid),
    .up_ready (term_ready),
    .up_data  (terms),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (result)
  );

  // Pack the result word, lowest field first
  assign out_tdata = {result.bottom_rotor, result.top_rotor, result.servo_b, result.servo_a};

endmodule
